// File: rtl/apnc_pkg.sv
// shared types, constants and palette table for the nearest palette color block
package apnc_pkg;

  localparam int unsigned CHAN_W      = 8;
  localparam int unsigned IDX_W       = 8;
  localparam int unsigned SQ_W        = 2 * CHAN_W;
  localparam int unsigned DIST_W      = SQ_W + 2;
  localparam int unsigned LANES       = 16;
  localparam int unsigned LANE_W      = 4;
  localparam int unsigned GROUP_W     = IDX_W - LANE_W;
  localparam int unsigned TREE_OUT    = 4;
  localparam int unsigned NUM_COLORS  = 256;
  localparam int unsigned STD_COLORS  = 16;
  localparam int unsigned CUBE_BASE   = 16;
  localparam int unsigned CUBE_SIDE   = 6;
  localparam int unsigned GRAY_BASE   = 232;
  localparam int unsigned GRAY_STEPS  = NUM_COLORS - GRAY_BASE;
  localparam int unsigned CUBE_OFFSET = 55;
  localparam int unsigned CUBE_STEP   = 40;
  localparam int unsigned GRAY_OFFSET = 8;
  localparam int unsigned GRAY_STEP   = 10;

  // last group of lanes for each search range
  localparam logic [GROUP_W-1:0] GRP_STD_LAST = '0;
  localparam logic [GROUP_W-1:0] GRP_ALL_LAST = '1;

  typedef logic [CHAN_W-1:0] chan_t;

  typedef struct packed {
    chan_t r;
    chan_t g;
    chan_t b;
  } rgb_t;

  typedef rgb_t [NUM_COLORS-1:0] palette_t;

  typedef struct packed {
    rgb_t               pix;
    logic [GROUP_W-1:0] last_grp;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_DRAIN
  } back_state_e;

  localparam rgb_t STD_TABLE [STD_COLORS] = '{
    '{8'd0,   8'd0,   8'd0},   '{8'd128, 8'd0,   8'd0},
    '{8'd0,   8'd128, 8'd0},   '{8'd128, 8'd128, 8'd0},
    '{8'd0,   8'd0,   8'd128}, '{8'd128, 8'd0,   8'd128},
    '{8'd0,   8'd128, 8'd128}, '{8'd192, 8'd192, 8'd192},
    '{8'd128, 8'd128, 8'd128}, '{8'd255, 8'd0,   8'd0},
    '{8'd0,   8'd255, 8'd0},   '{8'd255, 8'd255, 8'd0},
    '{8'd0,   8'd0,   8'd255}, '{8'd255, 8'd0,   8'd255},
    '{8'd0,   8'd255, 8'd255}, '{8'd255, 8'd255, 8'd255}
  };

  function automatic chan_t cube_level(int v);
    return (v == 0) ? '0 : CHAN_W'(CUBE_OFFSET + v * CUBE_STEP);
  endfunction

  // standard colors, then the 6x6x6 cube, then the gray ramp
  function automatic palette_t build_palette();
    palette_t pal;
    int       n;
    chan_t    gv;
    pal = '0;
    for (int i = 0; i < STD_COLORS; i++) begin
      pal[i] = STD_TABLE[i];
    end
    n = CUBE_BASE;
    for (int r = 0; r < CUBE_SIDE; r++) begin
      for (int g = 0; g < CUBE_SIDE; g++) begin
        for (int b = 0; b < CUBE_SIDE; b++) begin
          pal[n] = '{cube_level(r), cube_level(g), cube_level(b)};
          n++;
        end
      end
    end
    for (int k = 0; k < GRAY_STEPS; k++) begin
      gv = CHAN_W'(GRAY_OFFSET + k * GRAY_STEP);
      pal[GRAY_BASE + k] = '{gv, gv, gv};
    end
    return pal;
  endfunction

  localparam palette_t PALETTE = build_palette();

  function automatic logic [SQ_W-1:0] sq_diff(chan_t a, chan_t b);
    chan_t d;
    d = (a > b) ? (a - b) : (b - a);
    return {{CHAN_W{1'b0}}, d} * {{CHAN_W{1'b0}}, d};
  endfunction

endpackage

// File: rtl/apnc_front.sv
// front end: mode register, pixel acceptance and search range classification
module apnc_front import apnc_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   cfg_we_i,
  input  logic   cfg_wdata_i,
  input  logic   in_valid_i,
  output logic   in_stall_o,
  input  chan_t  red_i,
  input  chan_t  green_i,
  input  chan_t  blue_i,
  input  logic   q_full_i,
  output logic   q_push_o,
  output job_t   q_data_o
);

  logic mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    q_data_o.pix      = '{red_i, green_i, blue_i};
    q_data_o.last_grp = mode_q ? GRP_ALL_LAST : GRP_STD_LAST;
  end

endmodule

// File: rtl/apnc_queue.sv
// small job queue between front end and search engine
module apnc_queue import apnc_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t push_data_i,
  output logic full_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  job_t             mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// File: rtl/apnc_back.sv
// search engine: sixteen candidate lanes per cycle, min tree, running best, output register
module apnc_back import apnc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             job_valid_i,
  input  job_t             job_i,
  output logic             job_pop_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [IDX_W-1:0] color_index_o
);

  back_state_e state_q, state_d;

  job_t               job_q;
  logic [GROUP_W-1:0] grp_q, grp_d;
  logic               issue;

  // stage 1: per lane squared component differences
  logic               s1_vld_q;
  logic [GROUP_W-1:0] s1_grp_q;
  logic [SQ_W-1:0]    s1_sq_r_q [LANES];
  logic [SQ_W-1:0]    s1_sq_g_q [LANES];
  logic [SQ_W-1:0]    s1_sq_b_q [LANES];

  // stage 2: per lane distance
  logic               s2_vld_q;
  logic [GROUP_W-1:0] s2_grp_q;
  logic [DIST_W-1:0]  s2_dist_q [LANES];

  // stage 3: two tree levels, four survivors
  logic               s3_vld_q;
  logic               s3_first_q;
  logic [DIST_W-1:0]  s3_dist_q [TREE_OUT];
  logic [IDX_W-1:0]   s3_idx_q  [TREE_OUT];

  logic [DIST_W-1:0]  best_dist_q;
  logic [IDX_W-1:0]   best_idx_q;

  logic               out_valid_q;
  logic [IDX_W-1:0]   out_idx_q;
  logic               pipe_empty, out_free, load_out;

  logic [DIST_W-1:0]  l1_dist [LANES/2];
  logic [IDX_W-1:0]   l1_idx  [LANES/2];
  logic [DIST_W-1:0]  l2_dist [TREE_OUT];
  logic [IDX_W-1:0]   l2_idx  [TREE_OUT];
  logic [DIST_W-1:0]  m1_dist [TREE_OUT/2];
  logic [IDX_W-1:0]   m1_idx  [TREE_OUT/2];
  logic [DIST_W-1:0]  m2_dist;
  logic [IDX_W-1:0]   m2_idx;
  logic               take_new;

  assign pipe_empty = !s1_vld_q && !s2_vld_q && !s3_vld_q;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d   = state_q;
    grp_d     = grp_q;
    job_pop_o = 1'b0;
    issue     = 1'b0;
    load_out  = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          grp_d     = '0;
          state_d   = BK_RUN;
        end
      end
      BK_RUN: begin
        issue = 1'b1;
        grp_d = grp_q + 1'b1;
        if (grp_q == job_q.last_grp) begin
          state_d = BK_DRAIN;
        end
      end
      BK_DRAIN: begin
        if (pipe_empty && out_free) begin
          load_out = 1'b1;
          state_d  = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  // lower index on the left keeps it on ties
  always_comb begin
    for (int i = 0; i < LANES / 2; i++) begin
      if (s2_dist_q[2*i+1] < s2_dist_q[2*i]) begin
        l1_dist[i] = s2_dist_q[2*i+1];
        l1_idx[i]  = {s2_grp_q, LANE_W'(2*i+1)};
      end else begin
        l1_dist[i] = s2_dist_q[2*i];
        l1_idx[i]  = {s2_grp_q, LANE_W'(2*i)};
      end
    end
    for (int i = 0; i < TREE_OUT; i++) begin
      if (l1_dist[2*i+1] < l1_dist[2*i]) begin
        l2_dist[i] = l1_dist[2*i+1];
        l2_idx[i]  = l1_idx[2*i+1];
      end else begin
        l2_dist[i] = l1_dist[2*i];
        l2_idx[i]  = l1_idx[2*i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < TREE_OUT / 2; i++) begin
      if (s3_dist_q[2*i+1] < s3_dist_q[2*i]) begin
        m1_dist[i] = s3_dist_q[2*i+1];
        m1_idx[i]  = s3_idx_q[2*i+1];
      end else begin
        m1_dist[i] = s3_dist_q[2*i];
        m1_idx[i]  = s3_idx_q[2*i];
      end
    end
    if (m1_dist[1] < m1_dist[0]) begin
      m2_dist = m1_dist[1];
      m2_idx  = m1_idx[1];
    end else begin
      m2_dist = m1_dist[0];
      m2_idx  = m1_idx[0];
    end
    take_new = s3_vld_q && (s3_first_q || (m2_dist < best_dist_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      grp_q       <= '0;
      s1_vld_q    <= 1'b0;
      s2_vld_q    <= 1'b0;
      s3_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      grp_q    <= grp_d;
      s1_vld_q <= issue;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      job_q <= job_i;
    end
    s1_grp_q <= grp_q;
    for (int l = 0; l < LANES; l++) begin
      s1_sq_r_q[l] <= sq_diff(job_q.pix.r, PALETTE[{grp_q, LANE_W'(l)}].r);
      s1_sq_g_q[l] <= sq_diff(job_q.pix.g, PALETTE[{grp_q, LANE_W'(l)}].g);
      s1_sq_b_q[l] <= sq_diff(job_q.pix.b, PALETTE[{grp_q, LANE_W'(l)}].b);
    end
    s2_grp_q <= s1_grp_q;
    for (int l = 0; l < LANES; l++) begin
      s2_dist_q[l] <= DIST_W'(s1_sq_r_q[l]) + DIST_W'(s1_sq_g_q[l]) + DIST_W'(s1_sq_b_q[l]);
    end
    s3_first_q <= (s2_grp_q == '0);
    for (int i = 0; i < TREE_OUT; i++) begin
      s3_dist_q[i] <= l2_dist[i];
      s3_idx_q[i]  <= l2_idx[i];
    end
    if (take_new) begin
      best_dist_q <= m2_dist;
      best_idx_q  <= m2_idx;
    end
    if (load_out) begin
      out_idx_q <= best_idx_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign color_index_o = out_idx_q;

endmodule

// File: rtl/ansi_palette_nearest_color_core.sv
// top level: nearest terminal palette color search for one rgb pixel per item
// from accept to result valid the engine takes the job from the queue, walks the lane groups
// (all sixteen for the full palette, only the first for the 16 standard colors), drains
// stages 1 to 3 into the running best and loads the output register; the search engine finishes
// one pixel before it takes the next from the job queue
// reset: queue and output empty, engine idle, palette_mode set to full palette
module ansi_palette_nearest_color_core import apnc_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       red_i,
  input  logic [7:0]       green_i,
  input  logic [7:0]       blue_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [IDX_W-1:0] color_index_o
);

  // front to queue
  logic q_push;
  logic q_full;
  job_t q_wdata;

  // queue to engine
  logic q_valid;
  logic q_pop;
  job_t q_rdata;

  // front end holds the mode register and tags each item with its last lane group
  apnc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_data_o    (q_wdata)
  );

  // short queue so new pixels keep coming in while the engine searches
  apnc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_wdata),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .data_o      (q_rdata)
  );

  // engine walks lane groups, keeps the lowest index on equal distance,
  // and parks the answer in an output register so it can run ahead
  apnc_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (q_valid),
    .job_i         (q_rdata),
    .job_pop_o     (q_pop),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .color_index_o (color_index_o)
  );

endmodule

// File: test/tb_ansi_palette_nearest_color_core.sv
// testbench for the nearest terminal palette color core: directed and random pixels checked against a predictor
module tb_ansi_palette_nearest_color_core;
  import apnc_pkg::*;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pixel_t;

  // one pixel sent and the palette index it should map to
  typedef struct packed {
    pixel_t     px;
    logic [7:0] idx;
  } match_t;

  // the 16 standard colors as {r, g, b}
  localparam logic [23:0] BASE_COLORS [16] = '{
    24'h000000, 24'h800000, 24'h008000, 24'h808000,
    24'h000080, 24'h800080, 24'h008080, 24'hC0C0C0,
    24'h808080, 24'hFF0000, 24'h00FF00, 24'hFFFF00,
    24'h0000FF, 24'hFF00FF, 24'h00FFFF, 24'hFFFFFF
  };

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic             cfg_wdata_i = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic [7:0]       red_i = '0;
  logic [7:0]       green_i = '0;
  logic [7:0]       blue_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [IDX_W-1:0] color_index_o;

  pixel_t pending_pixels [$];
  match_t expected_matches [$];

  logic palette_full = 1'b1;   // predictor copy of palette_mode, reset value is full palette
  int     items_issued = 0;
  int     results_seen = 0;
  int     fail_count = 0;
  int     send_gap = 0;
  int     recv_hold = 0;
  bit     send_steady = 1'b0;
  bit     recv_steady = 1'b0;

  ansi_palette_nearest_color_core i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .red_i         (red_i),
    .green_i       (green_i),
    .blue_i        (blue_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .color_index_o (color_index_o)
  );

  // 4 time unit clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // color of palette entry n: standard table, 6x6x6 cube, then gray ramp
  function automatic pixel_t palette_color(int n);
    pixel_t c;
    int     k;
    int     lv [3];
    if (n < 16) begin
      c = BASE_COLORS[n];
    end else if (n < 232) begin
      k = n - 16;
      lv[0] = k / 36;
      lv[1] = (k / 6) % 6;
      lv[2] = k % 6;
      for (int j = 0; j < 3; j++) begin
        lv[j] = (lv[j] == 0) ? 0 : 55 + 40 * lv[j];
      end
      c = {lv[0][7:0], lv[1][7:0], lv[2][7:0]};
    end else begin
      k = 8 + 10 * (n - 232);
      c = {k[7:0], k[7:0], k[7:0]};
    end
    return c;
  endfunction

  // exhaustive search, strict less-than keeps the lowest index on a tie
  function automatic logic [7:0] nearest_index(pixel_t px, logic full);
    pixel_t     c;
    int         last;
    int         dr, dg, db, d, best_d;
    logic [7:0] best;
    last = full ? 255 : 15;
    best = '0;
    best_d = 0;
    for (int n = 0; n <= last; n++) begin
      c = palette_color(n);
      dr = int'(px.r) - int'(c.r);
      dg = int'(px.g) - int'(c.g);
      db = int'(px.b) - int'(c.b);
      d = dr * dr + dg * dg + db * db;
      if (n == 0 || d < best_d) begin
        best_d = d;
        best = n[7:0];
      end
    end
    return best;
  endfunction

  // small random offset around a channel value, clamped to 0..255
  function automatic logic [7:0] jitter(logic [7:0] v);
    int t;
    t = int'(v) + int'($urandom_range(0, 8)) - 4;
    if (t < 0) t = 0;
    if (t > 255) t = 255;
    return t[7:0];
  endfunction

  task automatic queue_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    pending_pixels.insert(pending_pixels.size(), pixel_t'({r, g, b}));
    items_issued++;
  endtask

  // a third uniform, a third near a palette entry, a third at the midpoint of two entries
  // (midpoints with even sums land exactly on distance ties)
  task automatic queue_random(input int count);
    pixel_t a, c;
    int     top;
    top = palette_full ? 255 : 15;
    for (int n = 0; n < count; n++) begin
      case ($urandom_range(0, 2))
        0: begin
          a = 24'($urandom);
        end
        1: begin
          c = palette_color($urandom_range(0, top));
          a = {jitter(c.r), jitter(c.g), jitter(c.b)};
        end
        default: begin
          c = palette_color($urandom_range(0, top));
          a = palette_color($urandom_range(0, top));
          a.r = 8'((int'(a.r) + int'(c.r)) / 2);
          a.g = 8'((int'(a.g) + int'(c.g)) / 2);
          a.b = 8'((int'(a.b) + int'(c.b)) / 2);
        end
      endcase
      queue_pixel(a.r, a.g, a.b);
    end
  endtask

  // change palette_mode only once every issued item has come back
  task automatic set_palette_mode(input logic full);
    wait (results_seen == items_issued);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= full;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    palette_full = full;
  endtask

  // sender: one item per handshake, a random gap ahead of each, or none in steady stretches
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        expected_matches.insert(expected_matches.size(),
                                match_t'({red_i, green_i, blue_i,
                                          nearest_index({red_i, green_i, blue_i},
                                                        palette_full)}));
      end
      // payload may only move when nothing is held under stall
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap > 0) begin
          in_valid_i <= 1'b0;
          send_gap--;
        end else if (pending_pixels.size() > 0) begin
          {red_i, green_i, blue_i} <= pending_pixels.pop_front();
          in_valid_i <= 1'b1;
          // occasional stretches of back-to-back items
          if ($urandom_range(0, 31) == 0) send_steady = !send_steady;
          send_gap = send_steady ? 0 : $urandom_range(0, 6);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver: check each accepted item against the oldest prediction, then stall for a random stretch
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (expected_matches.size() == 0) begin
          $display("%0t: unexpected color_index item, expected none, actual %0d",
                   $time, color_index_o);
          fail_count++;
        end else begin
          match_t m;
          m = expected_matches.pop_front();
          if (color_index_o !== m.idx) begin
            $display("%0t: color_index for rgb %0d,%0d,%0d: expected %0d, actual %0d",
                     $time, m.px.r, m.px.g, m.px.b, m.idx, color_index_o);
            fail_count++;
          end
        end
        if ($urandom_range(0, 31) == 0) recv_steady = !recv_steady;
        recv_hold = recv_steady ? 0 : $urandom_range(0, 6);
      end
      // the stall runs whether or not a result is waiting, so it hits every phase
      if (recv_hold > 0) begin
        out_stall_i <= 1'b1;
        recv_hold--;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // full palette straight from reset
    queue_pixel(8'd0,   8'd0,   8'd0);     // black: standard 0 ties cube 16
    queue_pixel(8'd255, 8'd255, 8'd255);   // white: standard 15 ties cube 231
    queue_pixel(8'd255, 8'd0,   8'd0);     // standard red ties cube corner
    queue_pixel(8'd128, 8'd128, 8'd128);   // standard gray ties ramp entry
    queue_pixel(8'd13,  8'd13,  8'd13);    // halfway between the two darkest ramp steps
    queue_pixel(8'd238, 8'd238, 8'd238);   // top of the gray ramp
    queue_pixel(8'd95,  8'd135, 8'd175);   // exact cube entry
    queue_pixel(8'd115, 8'd115, 8'd115);   // between cube gray and ramp
    queue_pixel(8'd1,   8'd254, 8'd127);
    queue_pixel(8'd170, 8'd85,  8'd0);
    queue_pixel(8'd27,  8'd0,   8'd28);    // near black, between cube levels
    queue_pixel(8'd254, 8'd1,   8'd200);
    queue_random(300);

    // standard colors only
    set_palette_mode(1'b0);
    queue_pixel(8'd0,   8'd0,   8'd0);
    queue_pixel(8'd255, 8'd255, 8'd255);
    queue_pixel(8'd64,  8'd0,   8'd0);     // tie between black and maroon
    queue_pixel(8'd160, 8'd160, 8'd160);   // tie between silver and gray
    queue_pixel(8'd192, 8'd192, 8'd192);
    queue_pixel(8'd128, 8'd0,   8'd128);
    queue_pixel(8'd0,   8'd255, 8'd255);
    queue_pixel(8'd64,  8'd64,  8'd64);    // equidistant black and gray
    queue_pixel(8'd200, 8'd30,  8'd250);
    queue_random(250);

    set_palette_mode(1'b1);
    queue_random(250);
    set_palette_mode(1'b0);
    queue_random(100);
    set_palette_mode(1'b1);
    queue_random(100);

    wait (results_seen == items_issued);
    // let any extra result from the search pipeline show up
    repeat (40) @(posedge clk_i);
    if (expected_matches.size() != 0) begin
      $display("%0t: %0d color_index items never arrived, expected %0d, actual none",
               $time, expected_matches.size(), expected_matches[0].idx);
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("** ansi_palette_nearest_color_core: PASSED **");
    end else begin
      $display("** ansi_palette_nearest_color_core: FAILED **");
    end
    $finish;
  end

  // watchdog, far above the slowest legal run
  initial begin
    #2000000;
    $display("** ansi_palette_nearest_color_core: FAILED **");
    $finish;
  end

endmodule
